/* src/mrss_pkg.sv */
// ----------------------------------------------------------------------------
// mrss_pkg
// Shared types, protocol codes and the CRC-16 byte update for the Modbus RTU
// slave register server.
// ----------------------------------------------------------------------------
package mrss_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
        logic       rx_error;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_tx_item;

    // Request from the frame sequencer to the response emitter.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_emit_req;

    localparam logic [7:0]  FUNC_READ  = 8'd3;
    localparam logic [7:0]  FUNC_WRITE = 8'd16;
    localparam logic [7:0]  EXC_FUNC   = 8'd1;
    localparam logic [7:0]  EXC_ADDR   = 8'd2;
    localparam logic [7:0]  EXC_FLAG   = 8'h80;
    localparam logic [7:0]  BCAST_ADDR = 8'd0;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam int          HDR_BYTES  = 6;

    // Reflected CRC-16 over one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* src/mrss_tx_emit.sv */
// ----------------------------------------------------------------------------
// mrss_tx_emit
// Response emitter: registers message bytes onto the output channel, keeps
// the running CRC and appends it, low byte first, after the last byte.
// ----------------------------------------------------------------------------
module mrss_tx_emit
    import mrss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_emit_req i_req,
    output logic      o_ready,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_tx_item  o_out
);

    logic        r_out_valid;
    t_tx_item    r_out;
    logic [1:0]  r_tail;
    logic [15:0] r_crc;
    logic        slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_ready     = slot_free && (r_tail == 2'd0);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tail      <= 2'd0;
            r_crc       <= CRC_INIT;
        end else if (slot_free) begin
            if (r_tail == 2'd2) begin
                r_out       <= '{tx_byte: r_crc[7:0], tx_last: 1'b0};
                r_out_valid <= 1'b1;
                r_tail      <= 2'd1;
            end else if (r_tail == 2'd1) begin
                r_out       <= '{tx_byte: r_crc[15:8], tx_last: 1'b1};
                r_out_valid <= 1'b1;
                r_tail      <= 2'd0;
                r_crc       <= CRC_INIT;
            end else if (i_req.valid) begin
                r_out       <= '{tx_byte: i_req.data, tx_last: 1'b0};
                r_out_valid <= 1'b1;
                r_crc       <= crc_byte(r_crc, i_req.data);
                r_tail      <= i_req.last ? 2'd2 : 2'd0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* src/modbus_rtu_slave_register_server.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server
// Modbus RTU slave serving 16-bit holding registers (functions 3 and 16).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one received byte
//   per item, with frame_end on the last byte of a frame and rx_error on a
//   byte that had a line error. Bytes are taken one per cycle while a frame
//   is being collected. On the frame_end item the block holds stall high,
//   judges the frame in S_JUDGE, then runs the request: a write steps
//   through S_WRA, S_WRB, S_WRC per register, a read through S_RDREQ,
//   S_RDHI, S_RDLO per word, and response bytes stream out at up to one
//   per cycle. The frame buffer has a write and a read port, reg_mem one port.
//   Output channel (o_out_valid / i_out_stall / o_out) carries the response
//   bytes, CRC last (low byte, then high byte with tx_last set). A stall on
//   the output holds the current byte and pauses the sequencer; no byte is
//   lost or repeated.
//   Dropped frames (line error, overflow, bad CRC, runt, foreign address,
//   broadcast or oversized reply) produce nothing.
//   Reset: the register memory is swept to zero, one entry per cycle, over
//   all NUM_REGS entries; input stays stalled meanwhile. The station address
//   resets to 1; write it through i_cfg_wr_en only while nothing is in flight.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_server
    import mrss_pkg::*;
#(
    parameter int BUFFER_BYTES = 64,
    parameter int NUM_REGS     = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_rx_item i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_tx_item o_out,
    input  logic     i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_RX    = 12'b0000_0000_0010,
        S_JUDGE = 12'b0000_0000_0100,
        S_EXC   = 12'b0000_0000_1000,
        S_ECHO  = 12'b0000_0001_0000,
        S_RDHDR = 12'b0000_0010_0000,
        S_RDREQ = 12'b0000_0100_0000,
        S_RDHI  = 12'b0000_1000_0000,
        S_RDLO  = 12'b0001_0000_0000,
        S_WRA   = 12'b0010_0000_0000,
        S_WRB   = 12'b0100_0000_0000,
        S_WRC   = 12'b1000_0000_0000
    } t_state;

    // Memories: received frame bytes and holding registers.
    logic [7:0]  frame_mem [BUFFER_BYTES];
    logic [15:0] reg_mem   [NUM_REGS];

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic        r_bad, n_bad;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_hdr [HDR_BYTES];
    logic [7:0]  n_hdr [HDR_BYTES];
    logic [2:0]  r_k, n_k;
    logic [15:0] r_w, n_w;
    logic        r_bcast, n_bcast;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_hi, n_hi;
    logic [RW-1:0] r_clr, n_clr;
    logic [7:0]  r_slave;
    logic        r_fok, n_fok;
    logic [7:0]  r_fdata;
    logic [15:0] r_rdata;

    logic        fm_we, fm_re, rm_we, rm_re;
    logic [AW-1:0] fm_wa, fm_ra;
    logic [RW-1:0] rm_wa, rm_ra;
    logic [15:0] rm_wd;

    t_emit_req   emit_req;
    logic        emit_ready;

    logic        in_acc;
    logic [15:0] start, qty;
    logic [16:0] wr_reg, rng_end;
    logic [17:0] rd_len, pos;
    logic        addr_ok;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_RX);
    assign start      = {r_hdr[2], r_hdr[3]};
    assign qty        = {r_hdr[4], r_hdr[5]};
    assign wr_reg     = {1'b0, start} + {1'b0, r_w};
    assign rng_end    = {1'b0, start} + {1'b0, qty};
    assign rd_len     = 18'd5 + {1'b0, qty, 1'b0};
    assign pos        = 18'd7 + {1'b0, r_w, 1'b0};
    assign addr_ok    = (r_hdr[0] == r_slave) || (r_hdr[0] == BCAST_ADDR);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_bad    = r_bad;
        n_crc    = r_crc;
        n_hdr    = r_hdr;
        n_k      = r_k;
        n_w      = r_w;
        n_bcast  = r_bcast;
        n_code   = r_code;
        n_hi     = r_hi;
        n_clr    = r_clr;
        n_fok    = r_fok;
        fm_we    = 1'b0;
        fm_wa    = r_count[AW-1:0];
        fm_re    = 1'b0;
        fm_ra    = pos[AW-1:0];
        rm_we    = 1'b0;
        rm_wa    = wr_reg[RW-1:0];
        rm_wd    = {r_hi, r_fok ? r_fdata : 8'h00};
        rm_re    = 1'b0;
        rm_ra    = wr_reg[RW-1:0];
        emit_req = '{valid: 1'b0, data: 8'h00, last: 1'b0};

        case (r_state)
            S_CLEAR: begin
                rm_we = 1'b1;
                rm_wa = r_clr;
                rm_wd = 16'h0000;
                n_clr = r_clr + RW'(1);
                if (r_clr == RW'(NUM_REGS - 1)) begin
                    n_state = S_RX;
                end
            end
            S_RX: begin
                if (in_acc) begin
                    if (i_in.rx_error) begin
                        n_bad = 1'b1;
                    end
                    if (r_count < CW'(BUFFER_BYTES)) begin
                        fm_we   = 1'b1;
                        n_count = r_count + CW'(1);
                        n_crc   = crc_byte(r_crc, i_in.rx_byte);
                        for (int h = 0; h < HDR_BYTES; h++) begin
                            if (r_count == CW'(h)) begin
                                n_hdr[h] = i_in.rx_byte;
                            end
                        end
                    end else begin
                        n_bad = 1'b1;
                    end
                    if (i_in.frame_end) begin
                        n_state = S_JUDGE;
                    end
                end
            end
            S_JUDGE: begin
                n_k     = 3'd0;
                n_w     = 16'd0;
                n_bcast = (r_hdr[0] == BCAST_ADDR);
                n_state = S_RX;
                if (!r_bad && r_count >= CW'(4) && r_crc == 16'h0000 && addr_ok) begin
                    if (r_hdr[1] == FUNC_READ) begin
                        if (r_hdr[0] != BCAST_ADDR) begin
                            if (qty != 16'd0 && rng_end > 17'(NUM_REGS)) begin
                                n_code  = EXC_ADDR;
                                n_state = S_EXC;
                            end else if (rd_len < 18'(BUFFER_BYTES)) begin
                                n_state = S_RDHDR;
                            end
                        end
                    end else if (r_hdr[1] == FUNC_WRITE) begin
                        n_state = S_WRA;
                    end else if (r_hdr[0] != BCAST_ADDR) begin
                        n_code  = EXC_FUNC;
                        n_state = S_EXC;
                    end
                end
            end
            S_EXC: begin
                if (emit_ready) begin
                    emit_req.valid = 1'b1;
                    emit_req.last  = (r_k == 3'd2);
                    case (r_k)
                        3'd0:    emit_req.data = r_hdr[0];
                        3'd1:    emit_req.data = r_hdr[1] | EXC_FLAG;
                        default: emit_req.data = r_code;
                    endcase
                    n_k = r_k + 3'd1;
                    if (r_k == 3'd2) begin
                        n_state = S_RX;
                    end
                end
            end
            S_ECHO: begin
                if (emit_ready) begin
                    emit_req.valid = 1'b1;
                    emit_req.data  = r_hdr[r_k];
                    emit_req.last  = (r_k == 3'(HDR_BYTES - 1));
                    n_k = r_k + 3'd1;
                    if (r_k == 3'(HDR_BYTES - 1)) begin
                        n_state = S_RX;
                    end
                end
            end
            S_RDHDR: begin
                if (emit_ready) begin
                    emit_req.valid = 1'b1;
                    emit_req.last  = (r_k == 3'd2) && (qty == 16'd0);
                    case (r_k)
                        3'd0:    emit_req.data = r_hdr[0];
                        3'd1:    emit_req.data = FUNC_READ;
                        default: emit_req.data = {qty[6:0], 1'b0};
                    endcase
                    n_k = r_k + 3'd1;
                    if (r_k == 3'd2) begin
                        n_state = (qty == 16'd0) ? S_RX : S_RDREQ;
                    end
                end
            end
            S_RDREQ: begin
                rm_re   = 1'b1;
                n_state = S_RDHI;
            end
            S_RDHI: begin
                if (emit_ready) begin
                    emit_req.valid = 1'b1;
                    emit_req.data  = r_rdata[15:8];
                    n_state        = S_RDLO;
                end
            end
            S_RDLO: begin
                if (emit_ready) begin
                    emit_req.valid = 1'b1;
                    emit_req.data  = r_rdata[7:0];
                    emit_req.last  = (r_w == qty - 16'd1);
                    n_w            = r_w + 16'd1;
                    n_state        = (r_w == qty - 16'd1) ? S_RX : S_RDREQ;
                end
            end
            S_WRA: begin
                if (r_w == qty || wr_reg >= 17'(NUM_REGS)) begin
                    n_code = EXC_ADDR;
                    if (r_bcast) begin
                        n_state = S_RX;
                    end else if (r_w != qty) begin
                        n_state = S_EXC;
                    end else begin
                        n_state = S_ECHO;
                    end
                end else begin
                    fm_re   = 1'b1;
                    fm_ra   = pos[AW-1:0];
                    n_fok   = (pos < 18'(r_count));
                    n_state = S_WRB;
                end
            end
            S_WRB: begin
                n_hi    = r_fok ? r_fdata : 8'h00;
                fm_re   = 1'b1;
                fm_ra   = pos[AW-1:0] + AW'(1);
                n_fok   = ((pos + 18'd1) < 18'(r_count));
                n_state = S_WRC;
            end
            S_WRC: begin
                rm_we   = 1'b1;
                n_w     = r_w + 16'd1;
                n_state = S_WRA;
            end
            default: begin
                n_state = S_RX;
            end
        endcase

        // Leaving the request: drop the frame and rearm for the next one.
        if (r_state != S_RX && r_state != S_CLEAR && n_state == S_RX) begin
            n_count = '0;
            n_bad   = 1'b0;
            n_crc   = CRC_INIT;
            for (int h = 0; h < HDR_BYTES; h++) begin
                n_hdr[h] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= '0;
            r_bad   <= 1'b0;
            r_crc   <= CRC_INIT;
            r_clr   <= '0;
            r_slave <= 8'd1;
            for (int h = 0; h < HDR_BYTES; h++) begin
                r_hdr[h] <= 8'h00;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_bad   <= n_bad;
            r_crc   <= n_crc;
            r_clr   <= n_clr;
            r_hdr   <= n_hdr;
            if (i_cfg_wr_en) begin
                r_slave <= i_cfg_wr_data;
            end
        end
        r_k     <= n_k;
        r_w     <= n_w;
        r_bcast <= n_bcast;
        r_code  <= n_code;
        r_hi    <= n_hi;
        r_fok   <= n_fok;
    end

    // Frame buffer: one write port from the receiver, one registered read.
    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            frame_mem[fm_wa] <= i_in.rx_byte;
        end
        if (fm_re) begin
            r_fdata <= frame_mem[fm_ra];
        end
    end

    // Holding registers: single port, registered read.
    always_ff @(posedge i_clk) begin
        if (rm_we) begin
            reg_mem[rm_wa] <= rm_wd;
        end
        if (rm_re) begin
            r_rdata <= reg_mem[rm_ra];
        end
    end

    mrss_tx_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (emit_req),
        .o_ready     (emit_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_BYTES))
        else $error("frame count beyond buffer");
    a_quiet_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("response during register sweep");
    a_req_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_req.valid |-> emit_ready)
        else $error("emit request while emitter busy");
    a_err_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRC) |-> (wr_reg < 17'(NUM_REGS)))
        else $error("register write out of range");
`endif

endmodule

/* dv/tb_modbus_rtu_slave_register_server.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_slave_register_server
// Self-checking bench for the Modbus RTU slave. It sends request frames byte by
// byte (good reads, writes, exceptions, broadcasts, bad CRC, line errors,
// overflow, runts, noise), predicts each response from its own model of the
// slave and checks every response byte in order.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_slave_register_server
    import mrss_pkg::*;
;

    localparam int FRAME_BYTES = 64;
    localparam int REG_COUNT   = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_WORDS   = 30;

    // Local CRC helper, written independently of the package.
    function automatic logic [15:0] next_crc(logic [15:0] c, logic [7:0] b);
        c ^= {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    // Predicts the slave's responses and holds the bytes still owed.
    class modbus_scoreboard;
        logic [7:0]  rx_buf[FRAME_BYTES];
        int          rx_len;
        bit          rx_drop;
        logic [15:0] regs[REG_COUNT];
        logic [7:0]  station;
        t_tx_item    owed_q[$];
        int          responses;

        function void clear();
            foreach (rx_buf[k]) rx_buf[k] = '0;
            foreach (regs[k]) regs[k] = '0;
            rx_len = 0;
            rx_drop = 0;
            station = 8'd1;
            owed_q.delete();
        endfunction

        function logic [7:0] rx_at(int k);
            return (k < rx_len) ? rx_buf[k] : 8'h00;
        endfunction

        // Queue msg plus its CRC, low byte first, if the reply fits.
        function void send_reply(logic [7:0] msg[$]);
            logic [15:0] c;
            t_tx_item    t;
            c = 16'hFFFF;
            if (msg.size() + 2 >= FRAME_BYTES) return;
            foreach (msg[k]) begin
                c = next_crc(c, msg[k]);
                t.tx_byte = msg[k];
                t.tx_last = 1'b0;
                owed_q.push_back(t);
            end
            t.tx_byte = c[7:0];
            owed_q.push_back(t);
            t.tx_byte = c[15:8];
            t.tx_last = 1'b1;
            owed_q.push_back(t);
            responses++;
        endfunction

        function void judge_frame();
            logic [15:0] c;
            logic [7:0]  addr, func;
            logic [7:0]  msg[$];
            int          start, qty;
            bit          bcast, bad;
            c = 16'hFFFF;
            if (rx_drop || rx_len < 4) return;
            for (int k = 0; k < rx_len; k++) c = next_crc(c, rx_buf[k]);
            if (c != 16'h0000) return;
            addr = rx_at(0);
            if (addr != station && addr != BCAST_ADDR) return;
            bcast = (addr == BCAST_ADDR);
            func = rx_at(1);
            start = {rx_at(2), rx_at(3)};
            qty = {rx_at(4), rx_at(5)};
            if (func == FUNC_READ) begin
                if (bcast) return;
                if (qty > 0 && start + qty > REG_COUNT) begin
                    msg = '{addr, func | EXC_FLAG, EXC_ADDR};
                end else begin
                    if (5 + 2 * qty >= FRAME_BYTES) return;
                    msg = '{addr, func, 8'((qty * 2) & 255)};
                    for (int k = 0; k < qty; k++) begin
                        msg.push_back(regs[start + k][15:8]);
                        msg.push_back(regs[start + k][7:0]);
                    end
                end
            end else if (func == FUNC_WRITE) begin
                bad = 0;
                for (int k = 0; k < qty; k++) begin
                    if (start + k >= REG_COUNT) begin
                        bad = 1;
                        break;
                    end
                    regs[start + k] = {rx_at(7 + 2 * k), rx_at(8 + 2 * k)};
                end
                if (bcast) return;
                if (bad) msg = '{addr, func | EXC_FLAG, EXC_ADDR};
                else for (int k = 0; k < HDR_BYTES; k++) msg.push_back(rx_at(k));
            end else begin
                if (bcast) return;
                msg = '{addr, func | EXC_FLAG, EXC_FUNC};
            end
            send_reply(msg);
        endfunction

        function void note_rx(t_rx_item it);
            if (it.rx_error) rx_drop = 1;
            if (rx_len < FRAME_BYTES) begin
                rx_buf[rx_len] = it.rx_byte;
                rx_len++;
            end else begin
                rx_drop = 1;
            end
            if (it.frame_end) begin
                judge_frame();
                rx_len = 0;
                rx_drop = 0;
            end
        endfunction

        // Returns 1 on a mismatch; the caller reports it.
        function bit check_tx(t_tx_item got, output string why);
            t_tx_item want;
            if (owed_q.size() == 0) begin
                why = $sformatf("unexpected byte %02h last=%0b", got.tx_byte, got.tx_last);
                return 1;
            end
            want = owed_q.pop_front();
            if (got.tx_byte !== want.tx_byte || got.tx_last !== want.tx_last) begin
                why = $sformatf("byte %02h last=%0b, want %02h last=%0b",
                                got.tx_byte, got.tx_last, want.tx_byte, want.tx_last);
                return 1;
            end
            return 0;
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_rx_item   i_in = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_tx_item   o_out;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd1;

    modbus_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  cycles = 0;
    int  mismatches = 0;
    int  sent_items = 0;
    int  checked_bytes = 0;

    modbus_rtu_slave_register_server #(
        .BUFFER_BYTES(FRAME_BYTES),
        .NUM_REGS(REG_COUNT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string why);
        $display("[%0t] MISMATCH: %s", $realtime, why);
        mismatches++;
    endtask

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("modbus_rtu_slave_register_server verification failed");
            $finish;
        end
    end

    // Receiver side: check each accepted byte, then pick the next stall.
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            checked_bytes++;
            if (sb.check_tx(o_out, why)) report_mismatch(why);
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Drive one byte; hold it until the slave takes it. Valid stays high
    // after the accept so that the next byte can follow with no gap.
    task automatic send_byte(logic [7:0] b, bit last_b, bit err_b = 1'b0);
        t_rx_item it;
        it.rx_byte = b;
        it.frame_end = last_b;
        it.rx_error = err_b;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_rx(it);
        sent_items++;
    endtask

    // Send body with its CRC appended; optionally corrupt the CRC or flag an error.
    task automatic send_frame(logic [7:0] body[$], bit bad_crc = 0, int err_at = -1);
        logic [15:0] c;
        logic [7:0]  f[$];
        c = 16'hFFFF;
        foreach (body[k]) c = next_crc(c, body[k]);
        if (bad_crc) c ^= 16'h0100 << $urandom_range(7);
        f = body;
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        foreach (f[k]) send_byte(f[k], k == f.size() - 1, k == err_at);
    endtask

    function automatic logic [7:0] pick_addr();
        case ($urandom_range(9))
            0: return BCAST_ADDR;
            1: return 8'($urandom);
            default: return sb.station;
        endcase
    endfunction

    task automatic send_read(logic [7:0] a, int start, int qty);
        send_frame('{a, FUNC_READ, 8'(start >> 8), 8'(start), 8'(qty >> 8), 8'(qty)});
    endtask

    // Data words beyond MAX_WORDS are left out of the frame.
    task automatic send_write(logic [7:0] a, int start, int qty, int words);
        logic [7:0] b[$];
        int         n;
        n = (words > MAX_WORDS) ? MAX_WORDS : words;
        b = '{a, FUNC_WRITE, 8'(start >> 8), 8'(start), 8'(qty >> 8), 8'(qty), 8'(2 * qty)};
        repeat (2 * n) b.push_back(8'($urandom));
        send_frame(b);
    endtask

    // Drop valid, wait until every owed byte has arrived, then let the slave settle.
    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_station(logic [7:0] a);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= a;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.station = a;
    endtask

    // Mostly well-formed requests with random content, plus noise.
    task automatic random_traffic(int n_items);
        int goal, start, qty;
        goal = sent_items + n_items;
        while (sent_items < goal) begin
            start = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(35);
            qty = ($urandom_range(5) == 0) ? $urandom_range(65535) : $urandom_range(8);
            case ($urandom_range(9))
                0, 1, 2: send_read(pick_addr(), start, qty);
                3, 4, 5: send_write(pick_addr(), start, qty,
                                    ($urandom_range(4) == 0) ? $urandom_range(qty) : qty);
                6: send_frame('{pick_addr(), 8'($urandom), 8'($urandom), 8'($urandom)});
                7: begin
                    send_frame('{sb.station, FUNC_READ, 8'h00, 8'(start), 8'h00, 8'(qty)},
                               $urandom_range(1), $urandom_range(7) - 1);
                end
                default: begin
                    // Raw noise: random bytes, ending a frame at random.
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), $urandom_range(3) == 0, $urandom_range(7) == 0);
                    send_byte(8'($urandom), 1'b1);
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: read/write basics and every drop and exception path.
        send_read(8'd1, 0, 2);
        send_write(8'd1, 0, 3, 3);
        send_read(8'd1, 0, 3);
        send_read(8'd1, 0, 0);                      // zero-count read succeeds
        send_read(8'd1, 31, 1);
        send_read(8'd1, 31, 2);                     // range runs off the end
        send_read(8'd1, 16'hFFFF, 2);               // range runs past the top, no wrap
        send_write(8'd1, 30, 4, 4);                 // partial write then exception
        send_read(8'd1, 28, 4);
        send_write(8'd0, 4, 2, 2);                  // broadcast write, silent
        send_read(8'd0, 4, 2);                      // broadcast read, silent
        send_read(8'd1, 4, 2);
        send_write(8'd1, 10, 8, 1);                 // data past the frame reads zero
        send_read(8'd1, 0, 29);                     // longest reply that fits, answered
        send_read(8'd1, 0, 28);
        send_frame('{8'd1, 8'd7, 8'hFF, 8'h00});    // unknown function
        send_frame('{8'd0, 8'hFF, 8'h00});          // unknown function, broadcast
        send_frame('{8'd1, FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd1}, 1);      // bad CRC
        send_frame('{8'd1, FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd1}, 0, 2);   // line error
        send_read(8'd9, 0, 1);                      // foreign address
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);                     // runt
        for (int k = 0; k < FRAME_BYTES; k++) send_byte(8'($urandom), 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);               // overflow, plus error bit set
        send_write(8'd1, 0, 6, 6);                  // multi-word write
        send_read(8'd1, 0, 4);

        // Random phases over station addresses and idling mixes.
        set_station(8'd247);
        random_traffic(14);
        set_station(8'd1);
        send_idle_pct = 79;
        random_traffic(14);
        drain();                                    // sender holds off until all replies are out
        send_idle_pct = 0;
        recv_stall_pct = 79;
        random_traffic(14);
        set_station(8'($urandom_range(2, 246)));
        send_idle_pct = 17;
        recv_stall_pct = 17;
        random_traffic(14);
        set_station(8'd0);                          // address 0 is handled as broadcast
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_traffic(14);
        drain();

        if (sb.owed_q.size() != 0)
            report_mismatch($sformatf("%0d response bytes never arrived", sb.owed_q.size()));
        $display("sent %0d request bytes, checked %0d response bytes in %0d responses",
                 sent_items, checked_bytes, sb.responses);
        $display("covered reads, writes, exceptions, broadcasts and dropped frames");
        if (mismatches == 0) begin
            $display("modbus_rtu_slave_register_server verification clean");
        end else begin
            $display("modbus_rtu_slave_register_server verification failed");
        end
        $finish;
    end
endmodule
